FILE: rtl/core/gnta_pkg.sv
// Shared types and constants for the greedy nearest task assigner.
package gnta_pkg;

    localparam int MAX_TASKS_DEF  = 16;
    localparam int COORD_BITS_DEF = 10;
    localparam int SLOT_BITS      = 4;
    localparam int IDENT_BITS     = 8;
    localparam int COUNT_BITS     = 5;
    localparam int KIND_BITS      = 2;

    localparam logic [COUNT_BITS-1:0] TASK_COUNT_RESET = COUNT_BITS'(16);

    typedef enum logic [KIND_BITS-1:0] {
        KIND_LOAD      = 2'd0,
        KIND_ASSIGNED  = 2'd1,
        KIND_NONE_LEFT = 2'd2
    } result_kind_t;

    typedef enum logic {
        OP_LOAD    = 1'b0,
        OP_REQUEST = 1'b1
    } op_t;

    // Control part of the search token that walks along the row of cells.
    typedef struct packed {
        logic valid;
        logic found;
    } chain_ctrl_t;

endpackage

FILE: rtl/core/gnta_cell.sv
// One task slot of the search chain: stores the slot and updates the passing token.
module gnta_cell
    import gnta_pkg::*;
#(
    parameter int MAX_TASKS  = MAX_TASKS_DEF,
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int INDEX      = 0,
    localparam int IDX_BITS  = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic [COUNT_BITS-1:0]   task_count,
    input  logic                    load_en,
    input  logic [SLOT_BITS-1:0]    load_slot,
    input  logic [COORD_BITS-1:0]   load_x,
    input  logic [COORD_BITS-1:0]   load_y,
    input  logic [IDENT_BITS-1:0]   load_ident,
    input  logic                    mark_en,
    input  logic [IDX_BITS-1:0]     mark_slot,
    input  chain_ctrl_t             in_ctrl,
    input  logic [COORD_BITS-1:0]   in_x,
    input  logic [COORD_BITS-1:0]   in_y,
    input  logic [COORD_BITS:0]     in_dist,
    input  logic [IDX_BITS-1:0]     in_slot,
    input  logic [IDENT_BITS-1:0]   in_ident,
    output chain_ctrl_t             out_ctrl,
    output logic [COORD_BITS-1:0]   out_x,
    output logic [COORD_BITS-1:0]   out_y,
    output logic [COORD_BITS:0]     out_dist,
    output logic [IDX_BITS-1:0]     out_slot,
    output logic [IDENT_BITS-1:0]   out_ident
);

    localparam int CNT_W  = ((IDX_BITS > COUNT_BITS) ? IDX_BITS : COUNT_BITS) + 1;
    localparam int SLOT_W = ((IDX_BITS > SLOT_BITS) ? IDX_BITS : SLOT_BITS) + 1;

    logic [COORD_BITS-1:0] row_reg;
    logic [COORD_BITS-1:0] col_reg;
    logic [IDENT_BITS-1:0] ident_reg;
    logic                  taken_reg;

    chain_ctrl_t           ctrl_reg;
    chain_ctrl_t           ctrl_next;
    logic [COORD_BITS-1:0] x_reg;
    logic [COORD_BITS-1:0] y_reg;
    logic [COORD_BITS:0]   dist_reg;
    logic [COORD_BITS:0]   dist_next;
    logic [IDX_BITS-1:0]   slot_reg;
    logic [IDX_BITS-1:0]   slot_next;
    logic [IDENT_BITS-1:0] ident_out_reg;
    logic [IDENT_BITS-1:0] ident_out_next;

    logic                  active;
    logic                  load_hit;
    logic                  mark_hit;
    logic [COORD_BITS-1:0] dx;
    logic [COORD_BITS-1:0] dy;
    logic [COORD_BITS:0]   cand_dist;
    logic                  better;

    assign active   = CNT_W'(INDEX) < CNT_W'(task_count);
    assign load_hit = load_en && (SLOT_W'(load_slot) == SLOT_W'(INDEX));
    assign mark_hit = mark_en && (mark_slot == IDX_BITS'(INDEX));

    assign dx        = (in_x >= row_reg) ? (in_x - row_reg) : (row_reg - in_x);
    assign dy        = (in_y >= col_reg) ? (in_y - col_reg) : (col_reg - in_y);
    assign cand_dist = {1'b0, dx} + {1'b0, dy};

    // Only a strictly smaller distance displaces the best so far, so ties keep the lower slot.
    assign better = in_ctrl.valid && active && !taken_reg &&
                    (!in_ctrl.found || (cand_dist < in_dist));

    always_comb
    begin
        ctrl_next.valid = in_ctrl.valid;
        ctrl_next.found = in_ctrl.found || better;
        dist_next       = better ? cand_dist : in_dist;
        slot_next       = better ? IDX_BITS'(INDEX) : in_slot;
        ident_out_next  = better ? ident_reg : in_ident;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_reg  <= '0;
            taken_reg <= 1'b0;
        end
        else
        begin
            ctrl_reg <= ctrl_next;
            if (load_hit)
            begin
                taken_reg <= 1'b0;
            end
            else if (mark_hit)
            begin
                taken_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg         <= in_x;
        y_reg         <= in_y;
        dist_reg      <= dist_next;
        slot_reg      <= slot_next;
        ident_out_reg <= ident_out_next;
        if (load_hit)
        begin
            row_reg   <= load_x;
            col_reg   <= load_y;
            ident_reg <= load_ident;
        end
    end

    assign out_ctrl  = ctrl_reg;
    assign out_x     = x_reg;
    assign out_y     = y_reg;
    assign out_dist  = dist_reg;
    assign out_slot  = slot_reg;
    assign out_ident = ident_out_reg;

endmodule

FILE: rtl/core/greedy_nearest_task_assigner.sv
// Top level of the greedy nearest task assigner: request launch, cell chain and result register.
//
// A load request writes one task slot and clears its taken mark; its result strobe (done) comes
// in the cycle after acceptance and busy stays low, so loads can be issued every cycle while no
// search is in progress. A robot request sends a search token down a row of MAX_TASKS cells,
// one slot per cycle; busy is high from the acceptance edge until the edge that registers the
// result, so a new request is taken only after the previous one is through. The length of the
// cell chain sets how long busy stays high. Results are shown on the result ports for exactly
// one cycle with done high and cannot be held off. task_count must be written only while the
// block is idle (not enforced by the block); values above MAX_TASKS search the whole table.
module greedy_nearest_task_assigner
    import gnta_pkg::*;
#(
    parameter int MAX_TASKS  = MAX_TASKS_DEF,
    parameter int COORD_BITS = COORD_BITS_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [COUNT_BITS-1:0]  cfg_data,
    input  logic                   start,
    output logic                   busy,
    input  logic                   op,
    input  logic [SLOT_BITS-1:0]   slot_index,
    input  logic [COORD_BITS-1:0]  pos_x,
    input  logic [COORD_BITS-1:0]  pos_y,
    input  logic [IDENT_BITS-1:0]  task_ident,
    output logic                   done,
    output logic [KIND_BITS-1:0]   result_kind,
    output logic [IDENT_BITS-1:0]  assigned_ident,
    output logic [SLOT_BITS-1:0]   chosen_slot,
    output logic [COORD_BITS:0]    distance
);

    localparam int IDX_BITS = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;

    logic [COUNT_BITS-1:0] task_count_reg;
    logic                  busy_reg;
    logic                  done_reg;
    result_kind_t          kind_reg;
    logic [IDENT_BITS-1:0] ident_reg;
    logic [SLOT_BITS-1:0]  slot_reg;
    logic [COORD_BITS:0]   dist_reg;

    logic                  launch_valid_reg;
    logic [COORD_BITS-1:0] launch_x_reg;
    logic [COORD_BITS-1:0] launch_y_reg;

    logic                  accept;
    logic                  load_en;
    logic                  mark_en;
    chain_ctrl_t           end_ctrl;

    chain_ctrl_t           chain_ctrl  [0:MAX_TASKS];
    logic [COORD_BITS-1:0] chain_x     [0:MAX_TASKS];
    logic [COORD_BITS-1:0] chain_y     [0:MAX_TASKS];
    logic [COORD_BITS:0]   chain_dist  [0:MAX_TASKS];
    logic [IDX_BITS-1:0]   chain_slot  [0:MAX_TASKS];
    logic [IDENT_BITS-1:0] chain_ident [0:MAX_TASKS];
    logic [MAX_TASKS:0]    chain_valid;

    assign accept  = start && !busy_reg;
    assign load_en = accept && (op == OP_LOAD);

    assign end_ctrl = chain_ctrl[MAX_TASKS];
    assign mark_en  = end_ctrl.valid && end_ctrl.found;

    assign chain_ctrl[0]  = {launch_valid_reg, 1'b0};
    assign chain_x[0]     = launch_x_reg;
    assign chain_y[0]     = launch_y_reg;
    assign chain_dist[0]  = '0;
    assign chain_slot[0]  = '0;
    assign chain_ident[0] = '0;

    genvar gi;
    generate
        for (gi = 0; gi < MAX_TASKS; gi++)
        begin : g_cell
            gnta_cell #(
                .MAX_TASKS  (MAX_TASKS),
                .COORD_BITS (COORD_BITS),
                .INDEX      (gi)
            ) u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .task_count (task_count_reg),
                .load_en    (load_en),
                .load_slot  (slot_index),
                .load_x     (pos_x),
                .load_y     (pos_y),
                .load_ident (task_ident),
                .mark_en    (mark_en),
                .mark_slot  (chain_slot[MAX_TASKS]),
                .in_ctrl    (chain_ctrl[gi]),
                .in_x       (chain_x[gi]),
                .in_y       (chain_y[gi]),
                .in_dist    (chain_dist[gi]),
                .in_slot    (chain_slot[gi]),
                .in_ident   (chain_ident[gi]),
                .out_ctrl   (chain_ctrl[gi+1]),
                .out_x      (chain_x[gi+1]),
                .out_y      (chain_y[gi+1]),
                .out_dist   (chain_dist[gi+1]),
                .out_slot   (chain_slot[gi+1]),
                .out_ident  (chain_ident[gi+1])
            );
        end

        for (gi = 0; gi <= MAX_TASKS; gi++)
        begin : g_valid
            assign chain_valid[gi] = chain_ctrl[gi].valid;
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            task_count_reg   <= TASK_COUNT_RESET;
            busy_reg         <= 1'b0;
            done_reg         <= 1'b0;
            launch_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                task_count_reg <= cfg_data;
            end
            launch_valid_reg <= accept && (op == OP_REQUEST);
            if (accept && (op == OP_REQUEST))
            begin
                busy_reg <= 1'b1;
            end
            else if (end_ctrl.valid)
            begin
                busy_reg <= 1'b0;
            end
            done_reg <= load_en || end_ctrl.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            launch_x_reg <= pos_x;
            launch_y_reg <= pos_y;
        end
        if (end_ctrl.valid)
        begin
            kind_reg  <= end_ctrl.found ? KIND_ASSIGNED : KIND_NONE_LEFT;
            ident_reg <= end_ctrl.found ? chain_ident[MAX_TASKS] : '0;
            slot_reg  <= end_ctrl.found ? SLOT_BITS'(chain_slot[MAX_TASKS]) : '0;
            dist_reg  <= end_ctrl.found ? chain_dist[MAX_TASKS] : '0;
        end
        else
        begin
            kind_reg  <= KIND_LOAD;
            ident_reg <= '0;
            slot_reg  <= '0;
            dist_reg  <= '0;
        end
    end

    assign busy           = busy_reg;
    assign done           = done_reg;
    assign result_kind    = kind_reg;
    assign assigned_ident = ident_reg;
    assign chosen_slot    = slot_reg;
    assign distance       = dist_reg;

`ifndef ASSERT_OFF
    a_single_token: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(chain_valid) <= 1)
        else $error("more than one search request in the cell chain");

    a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !busy_reg |-> (chain_valid == '0))
        else $error("search token present while not busy");

    a_end_gives_done: assert property (@(posedge clk) disable iff (!rst_n)
        end_ctrl.valid |=> (done && !busy && (result_kind != KIND_LOAD)))
        else $error("finished search did not produce a result");

    a_zero_unless_assigned: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (result_kind != KIND_ASSIGNED)) |->
            ((assigned_ident == '0) && (chosen_slot == '0) && (distance == '0)))
        else $error("result fields not zero for a non-assigned result");
`endif

endmodule
